### rtl/core/tsv_pkg.sv
package tsv_pkg;

  localparam int unsigned COUNT_W = 17;
  localparam logic [COUNT_W-1:0] COUNT_SAT = 17'h10000;

  localparam logic [7:0] CH_HASH   = 8'h23;
  localparam logic [7:0] CH_PLUS   = 8'h2B;
  localparam logic [7:0] CH_SEP    = 8'h2F;
  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_DOLLAR = 8'h24;

  localparam int unsigned PADDR_W = 3;
  localparam logic [PADDR_W-1:0] ADDR_CHECK_MODE = 3'd0;
  localparam logic [PADDR_W-1:0] ADDR_MAX_LENGTH = 3'd4;

  localparam logic [15:0] MAX_LENGTH_RST = 16'hFFFF;

  typedef enum logic [2:0] {
    ST_OK           = 3'd0,
    ST_EMPTY        = 3'd1,
    ST_TOO_LONG     = 3'd2,
    ST_NULL_BYTE    = 3'd3,
    ST_WILD_IN_NAME = 3'd4,
    ST_BAD_WILDCARD = 3'd5
  } status_t;

  typedef struct packed {
    logic       check_mode;
    logic [15:0] max_length;
  } cfg_t;

  typedef struct packed {
    logic [7:0] char_byte;
    logic       has_byte;
    logic       last_item;
  } item_t;

  typedef struct packed {
    status_t status;
    logic    system_topic;
  } result_t;

endpackage

### rtl/core/topic_string_validator.sv
// Topic string validator: checks an MQTT-style topic name or topic filter.
// Input stream (s_*): one request per string byte. s_tdata carries the byte,
// s_tuser flags whether the byte is present (0 allows an empty string or a
// bare terminator), s_tlast closes the string.
// Output stream (m_*): exactly one request per string, produced by the
// request carrying s_tlast. m_tdata[2:0] is the status (ok, empty, too long,
// null byte, wildcard in name, invalid wildcard), m_tuser the '$' prefix flag.
// APB port: check_mode at 0x0 (0 name, 1 filter), max_length at 0x4.
// Write registers only while the block is idle.
// Path: a request is taken into the input register; the string state
// and the result register update as it leaves that register, so a status
// is presented from the result register once its last request has left it.
// Throughput: one request per cycle; the whole byte check is a handful of
// compares and a 17-bit increment/compare between the two registers.
// Stall: a stalled m_tready holds the result; bytes that are not last keep
// flowing until a second last request reaches the input register.
// Reset (rst, synchronous): both stages empty, string state cleared,
// check_mode = 0 and max_length = 65535.
module topic_string_validator (
  input  logic                        clk,
  input  logic                        rst,
  // slave side
  input  logic                        s_tvalid,
  output logic                        s_tready,
  input  logic [7:0]                  s_tdata,   // [7:0] char_byte
  input  logic                        s_tuser,   // [0] has_byte
  input  logic                        s_tlast,   // last_item
  // master side
  output logic                        m_tvalid,
  input  logic                        m_tready,
  output logic [7:0]                  m_tdata,   // [2:0] status, [7:3] zero
  output logic                        m_tuser,   // [0] system_topic
  // configuration
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [tsv_pkg::PADDR_W-1:0] paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready
);

  tsv_pkg::cfg_t    cfg;
  tsv_pkg::item_t   in_item;
  tsv_pkg::result_t scan_res;
  tsv_pkg::result_t out_res;

  logic in_valid;
  logic out_free;
  logic consume;

  tsv_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // Input register; a byte that yields no result never waits on the output.
  assign out_free = ~m_tvalid | m_tready;
  assign consume  = in_valid & (~in_item.last_item | out_free);
  assign s_tready = ~in_valid | consume;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_item.char_byte <= s_tdata;
      in_item.has_byte  <= s_tuser;
      in_item.last_item <= s_tlast;
    end
  end

  tsv_scan u_scan (
    .clk     (clk),
    .rst     (rst),
    .consume (consume),
    .item    (in_item),
    .cfg     (cfg),
    .result  (scan_res)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (consume && in_item.last_item) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (consume && in_item.last_item) begin
      out_res <= scan_res;
    end
  end

  assign m_tdata = {5'b0, out_res.status};
  assign m_tuser = out_res.system_topic;

`ifndef SYNTHESIS
  a_reset_empties_output: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("result valid after reset");

  a_last_loads_result: assert property (@(posedge clk) disable iff (rst)
    (consume && in_item.last_item) |=> m_tvalid)
    else $error("last request did not produce a result");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |-> !(consume && in_item.last_item))
    else $error("pending result overwritten");

  a_status_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[2:0] <= tsv_pkg::ST_BAD_WILDCARD))
    else $error("status code out of range");

  a_empty_not_system: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && (out_res.status == tsv_pkg::ST_EMPTY)) |-> !m_tuser)
    else $error("empty string flagged as system topic");
`endif

endmodule

### rtl/core/tsv_cfg.sv
module tsv_cfg (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [tsv_pkg::PADDR_W-1:0] paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready,
  output tsv_pkg::cfg_t               cfg
);

  logic wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite & pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.check_mode <= 1'b0;
      cfg.max_length <= tsv_pkg::MAX_LENGTH_RST;
    end else if (wr_en) begin
      unique case (paddr)
        tsv_pkg::ADDR_CHECK_MODE: cfg.check_mode <= pwdata[0];
        tsv_pkg::ADDR_MAX_LENGTH: cfg.max_length <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr)
      tsv_pkg::ADDR_CHECK_MODE: prdata = {31'b0, cfg.check_mode};
      tsv_pkg::ADDR_MAX_LENGTH: prdata = {16'b0, cfg.max_length};
      default:                  prdata = 32'b0;
    endcase
  end

endmodule

### rtl/core/tsv_scan.sv
module tsv_scan (
  input  logic              clk,
  input  logic              rst,
  input  logic              consume,
  input  tsv_pkg::item_t    item,
  input  tsv_pkg::cfg_t     cfg,
  output tsv_pkg::result_t  result
);

  logic [tsv_pkg::COUNT_W-1:0] byte_count, byte_count_next;
  logic prev_was_separator, prev_was_separator_next;
  logic plus_needs_separator, plus_needs_separator_next;
  logic hash_seen, hash_seen_next;
  logic null_seen, null_seen_next;
  logic wildcard_error, wildcard_error_next;
  logic first_is_dollar, first_is_dollar_next;

  logic filter, is_hash, is_plus, is_sep;

  assign filter  = cfg.check_mode;
  assign is_hash = (item.char_byte == tsv_pkg::CH_HASH);
  assign is_plus = (item.char_byte == tsv_pkg::CH_PLUS);
  assign is_sep  = (item.char_byte == tsv_pkg::CH_SEP);

  // string state after this request's byte (if any)
  always_comb begin
    byte_count_next           = byte_count;
    prev_was_separator_next   = prev_was_separator;
    plus_needs_separator_next = plus_needs_separator;
    hash_seen_next            = hash_seen;
    null_seen_next            = null_seen;
    wildcard_error_next       = wildcard_error;
    first_is_dollar_next      = first_is_dollar;
    if (item.has_byte) begin
      wildcard_error_next = wildcard_error
                          | (filter & hash_seen)
                          | (filter & plus_needs_separator & ~is_sep)
                          | ((is_hash | is_plus) & (~filter | ~prev_was_separator));
      hash_seen_next            = hash_seen | (filter & is_hash);
      plus_needs_separator_next = filter & is_plus;
      null_seen_next            = null_seen | (item.char_byte == tsv_pkg::CH_NUL);
      first_is_dollar_next      = first_is_dollar
                                | ((byte_count == '0) & (item.char_byte == tsv_pkg::CH_DOLLAR));
      prev_was_separator_next   = is_sep;
      if (byte_count < tsv_pkg::COUNT_SAT) begin
        byte_count_next = byte_count + 1'b1;
      end
    end
  end

  // status priority: empty, too long, null byte, wildcard
  always_comb begin
    if (byte_count_next == '0) begin
      result.status = tsv_pkg::ST_EMPTY;
    end else if (byte_count_next > {1'b0, cfg.max_length}) begin
      result.status = tsv_pkg::ST_TOO_LONG;
    end else if (null_seen_next) begin
      result.status = tsv_pkg::ST_NULL_BYTE;
    end else if (wildcard_error_next) begin
      result.status = filter ? tsv_pkg::ST_BAD_WILDCARD : tsv_pkg::ST_WILD_IN_NAME;
    end else begin
      result.status = tsv_pkg::ST_OK;
    end
    result.system_topic = (byte_count_next != '0) & first_is_dollar_next;
  end

  always_ff @(posedge clk) begin
    if (rst || (consume && item.last_item)) begin
      byte_count           <= '0;
      prev_was_separator   <= 1'b1;
      plus_needs_separator <= 1'b0;
      hash_seen            <= 1'b0;
      null_seen            <= 1'b0;
      wildcard_error       <= 1'b0;
      first_is_dollar      <= 1'b0;
    end else if (consume) begin
      byte_count           <= byte_count_next;
      prev_was_separator   <= prev_was_separator_next;
      plus_needs_separator <= plus_needs_separator_next;
      hash_seen            <= hash_seen_next;
      null_seen            <= null_seen_next;
      wildcard_error       <= wildcard_error_next;
      first_is_dollar      <= first_is_dollar_next;
    end
  end

endmodule

### bench/tb_top.sv
module tb_top;

  // No handshake on any port for this long ends the run. The slowest
  // correct stretch is a long sender gap plus a long result stall plus a
  // settings change, well within the limit.
  localparam int unsigned HANG_LIMIT = 5000;
  // Extra wait after the last status, for requests that owe no status.
  localparam int unsigned DRAIN_CYCLES = 6;
  localparam int unsigned RANDOM_REQS = 1150;

  logic        clk;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata = '0;   // [7:0] char_byte
  logic        s_tuser = 1'b0; // [0] has_byte
  logic        s_tlast = 1'b0; // last_item
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [7:0]  m_tdata;        // [2:0] status, [7:3] zero
  logic        m_tuser;        // [0] system_topic
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [tsv_pkg::PADDR_W-1:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  topic_string_validator dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .s_tuser(s_tuser), .s_tlast(s_tlast),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .m_tuser(m_tuser),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // ---------------------------------------------------------------------
  // Own copy of the block: settings shadow and per-string state.
  // ---------------------------------------------------------------------
  logic                        mode_filter = 1'b0;
  logic [15:0]                 len_limit   = tsv_pkg::MAX_LENGTH_RST;
  logic [tsv_pkg::COUNT_W-1:0] str_len     = '0;
  logic after_sep   = 1'b1;  // start of string counts as a level edge
  logic plus_open   = 1'b0;  // '+' seen, next byte must be '/'
  logic hash_done   = 1'b0;  // '#' seen, nothing may follow
  logic nul_hit     = 1'b0;
  logic wild_bad    = 1'b0;
  logic dollar_lead = 1'b0;

  tsv_pkg::result_t pending_status[$];  // statuses still owed by the block

  int unsigned err_count     = 0;
  int unsigned reqs_sent     = 0;
  int unsigned statuses_seen = 0;
  int unsigned settings_used = 0;
  bit          tx_steady     = 1'b0;  // sender runs flat out
  bit          rx_steady     = 1'b0;  // receiver never stalls

  // Advance the string state by one accepted request; returns 1 and the
  // status when the request closes the string.
  function automatic bit topic_status_predict(input logic [7:0] c, input logic has,
                                              input logic last,
                                              output tsv_pkg::result_t res);
    if (has) begin
      if (mode_filter && hash_done)
        wild_bad = 1'b1;
      if (mode_filter && plus_open && c != tsv_pkg::CH_SEP)
        wild_bad = 1'b1;
      plus_open = 1'b0;
      if (c == tsv_pkg::CH_HASH) begin
        if (!mode_filter || !after_sep)
          wild_bad = 1'b1;
        if (mode_filter)
          hash_done = 1'b1;
      end else if (c == tsv_pkg::CH_PLUS) begin
        if (!mode_filter || !after_sep)
          wild_bad = 1'b1;
        if (mode_filter)
          plus_open = 1'b1;
      end
      if (c == tsv_pkg::CH_NUL)
        nul_hit = 1'b1;
      if (str_len == 0 && c == tsv_pkg::CH_DOLLAR)
        dollar_lead = 1'b1;
      after_sep = (c == tsv_pkg::CH_SEP);
      if (str_len < tsv_pkg::COUNT_SAT)
        str_len = str_len + 1'b1;
    end
    if (!last)
      return 1'b0;
    // fixed precedence: empty, too long, NUL, wildcard
    if (str_len == 0)
      res.status = tsv_pkg::ST_EMPTY;
    else if (str_len > {1'b0, len_limit})
      res.status = tsv_pkg::ST_TOO_LONG;
    else if (nul_hit)
      res.status = tsv_pkg::ST_NULL_BYTE;
    else if (wild_bad)
      res.status = mode_filter ? tsv_pkg::ST_BAD_WILDCARD : tsv_pkg::ST_WILD_IN_NAME;
    else
      res.status = tsv_pkg::ST_OK;
    res.system_topic = (str_len != 0) && dollar_lead;
    str_len     = '0;
    after_sep   = 1'b1;
    plus_open   = 1'b0;
    hash_done   = 1'b0;
    nul_hit     = 1'b0;
    wild_bad    = 1'b0;
    dollar_lead = 1'b0;
    return 1'b1;
  endfunction

  // ---------------------------------------------------------------------
  // Sender side
  // ---------------------------------------------------------------------
  // Mostly back-to-back, some short gaps, the odd long one.
  function automatic int gap_len();
    int r;
    if (tx_steady)
      return 0;
    r = $urandom_range(0, 99);
    if (r < 65)
      return 0;
    if (r < 93)
      return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // Called just after a rising edge; returns just after the edge that took
  // the request. tvalid stays high across back-to-back requests.
  task automatic push(input logic [7:0] c, input logic has, input logic last);
    int               g;
    tsv_pkg::result_t res;
    g = gap_len();
    if (g > 0) begin
      s_tvalid <= 1'b0;
      repeat (g) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= c;
    s_tuser  <= has;
    s_tlast  <= last;
    do @(posedge clk); while (!s_tready);
    reqs_sent++;
    if (topic_status_predict(c, has, last, res))
      pending_status.push_back(res);
  endtask

  // Let the pipe empty: all statuses back, then the latency once more since
  // bytes that are not last leave nothing in the queue to wait on.
  task automatic wait_idle();
    s_tvalid <= 1'b0;
    while (pending_status.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Setup and access phase; returns with psel and penable low.
  task automatic apb_write(input logic [tsv_pkg::PADDR_W-1:0] addr,
                           input logic [31:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_config(input logic mode, input logic [15:0] limit);
    wait_idle();
    apb_write(tsv_pkg::ADDR_CHECK_MODE, {31'b0, mode});
    apb_write(tsv_pkg::ADDR_MAX_LENGTH, {16'b0, limit});
    mode_filter = mode;
    len_limit   = limit;
    settings_used++;
  endtask

  // One random topic string. Mostly well-formed levels with random content,
  // the rest raw noise. With keep_open the string is left unterminated so
  // that it straddles the next settings change.
  task automatic random_topic(input bit keep_open);
    logic [7:0] txt[$];
    logic [7:0] pool[6];
    int kind, nlev, lev, w, n, i, r;
    pool = '{tsv_pkg::CH_HASH, tsv_pkg::CH_PLUS, tsv_pkg::CH_SEP,
             tsv_pkg::CH_DOLLAR, tsv_pkg::CH_NUL, 8'h61};
    kind = $urandom_range(0, 99);
    if (kind < 5 && !keep_open) begin
      push(8'($urandom_range(0, 255)), 1'b0, 1'b1);  // empty string
      return;
    end
    if (kind < 80) begin
      nlev = $urandom_range(1, 4);
      for (lev = 0; lev < nlev; lev++) begin
        if (lev > 0)
          txt.push_back(tsv_pkg::CH_SEP);
        r = $urandom_range(0, 99);
        if (r < 20)
          txt.push_back(tsv_pkg::CH_PLUS);
        else if (r < 28 && lev == nlev - 1)
          txt.push_back(tsv_pkg::CH_HASH);
        else if (r >= 33) begin
          if (lev == 0 && $urandom_range(0, 9) == 0)
            txt.push_back(tsv_pkg::CH_DOLLAR);
          w = $urandom_range(1, 4);
          repeat (w) begin
            if ($urandom_range(0, 15) == 0)
              txt.push_back(8'($urandom_range(128, 255)));
            else
              txt.push_back(8'h61 + 8'($urandom_range(0, 25)));
          end
        end
        // otherwise an empty level
      end
      if (txt.size() == 0)
        txt.push_back(tsv_pkg::CH_SEP);
    end else begin
      n = $urandom_range(1, 8);
      repeat (n) begin
        if ($urandom_range(0, 1))
          txt.push_back(8'($urandom_range(0, 255)));
        else
          txt.push_back(pool[$urandom_range(0, 5)]);
      end
    end
    r = $urandom_range(0, 99);  // < 12: close with a bare terminator
    for (i = 0; i < txt.size(); i++) begin
      if ($urandom_range(0, 19) == 0)
        push(8'($urandom_range(0, 255)), 1'b0, 1'b0);  // ignored filler
      push(txt[i], 1'b1, !keep_open && r >= 12 && i == txt.size() - 1);
    end
    if (!keep_open && r < 12)
      push(8'($urandom_range(0, 255)), 1'b0, 1'b1);
  endtask

  // ---------------------------------------------------------------------
  // Directed table: one topic string per row, under the settings of the row.
  // Rows with typed=1 carry a status readable straight off the rules; the
  // rest fall back on the predictor.
  // ---------------------------------------------------------------------
  typedef enum {END_ON_BYTE, END_BARE, END_OPEN} close_t;

  typedef struct {
    logic             mode;
    logic [15:0]      limit;
    string            text;
    int               nul_at;  // position turned into a NUL byte, -1 for none
    close_t           closing;
    bit               filler;  // ignored request before the final byte
    bit               typed;
    tsv_pkg::status_t st;
    logic             sys;
  } topic_row_t;

  topic_row_t topic_rows[$];

  task automatic add_row(input logic mode, input logic [15:0] limit, input string text,
                         input int nul_at, input close_t closing, input bit filler,
                         input bit typed, input tsv_pkg::status_t st, input logic sys);
    topic_row_t row;
    row.mode = mode;     row.limit = limit;     row.text = text;
    row.nul_at = nul_at; row.closing = closing; row.filler = filler;
    row.typed = typed;   row.st = st;           row.sys = sys;
    topic_rows.push_back(row);
  endtask

  // ---------------------------------------------------------------------
  // Receiver side: random stalls plus the scoreboard.
  // ---------------------------------------------------------------------
  int rx_hold = 0;

  always @(posedge clk) begin
    tsv_pkg::result_t want;
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        statuses_seen++;
        if (pending_status.size() == 0) begin
          err_count++;
          $display("%0t: unexpected status %0d sys %0b", $time, m_tdata[2:0], m_tuser);
        end else begin
          want = pending_status.pop_front();
          if (m_tdata != {5'b0, want.status}) begin
            err_count++;
            $display("%0t: status expected %s (%0d) got tdata %0h", $time,
                     want.status.name(), want.status, m_tdata);
          end
          if (m_tuser !== want.system_topic) begin
            err_count++;
            $display("%0t: system_topic expected %0b got %0b", $time,
                     want.system_topic, m_tuser);
          end
        end
      end
      if (rx_hold > 0) begin
        m_tready <= 1'b0;
        rx_hold  <= rx_hold - 1;
      end else if (!rx_steady && $urandom_range(0, 99) < 25) begin
        m_tready <= 1'b0;
        rx_hold  <= ($urandom_range(0, 9) == 0) ? $urandom_range(8, 30)
                                                : $urandom_range(0, 2);
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  // Watchdog: cycles with no handshake on any port.
  int unsigned hang_count = 0;

  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable && pready))
      hang_count <= 0;
    else
      hang_count <= hang_count + 1;
    if (hang_count == HANG_LIMIT) begin
      $display("%0t: no handshake for %0d cycles, %0d statuses owed", $time,
               HANG_LIMIT, pending_status.size());
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // ---------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------
  initial begin
    topic_row_t  row;
    int          i, n, base;
    logic        mode;
    logic [15:0] limit;
    logic [7:0]  c;

    // name mode, default limit: empty string first, straight after reset
    add_row(0, 16'hFFFF, "",           -1, END_ON_BYTE, 0, 1, tsv_pkg::ST_EMPTY,        0);
    add_row(0, 16'hFFFF, "a/b/c",      -1, END_ON_BYTE, 0, 1, tsv_pkg::ST_OK,           0);
    add_row(0, 16'hFFFF, "$SYS/up",    -1, END_ON_BYTE, 0, 1, tsv_pkg::ST_OK,           1);
    add_row(0, 16'hFFFF, "a/+/b",      -1, END_ON_BYTE, 0, 1, tsv_pkg::ST_WILD_IN_NAME, 0);
    add_row(0, 16'hFFFF, "#",          -1, END_ON_BYTE, 0, 1, tsv_pkg::ST_WILD_IN_NAME, 0);
    // NUL outranks a wildcard
    add_row(0, 16'hFFFF, "a+b",         0, END_ON_BYTE, 0, 1, tsv_pkg::ST_NULL_BYTE,    0);
    // top-bit bytes plus an ignored filler request
    add_row(0, 16'hFFFF, "/\377\200/", -1, END_ON_BYTE, 1, 1, tsv_pkg::ST_OK,           0);
    // filter mode
    add_row(1, 16'hFFFF, "+/a/#",      -1, END_ON_BYTE, 0, 1, tsv_pkg::ST_OK,           0);
    add_row(1, 16'hFFFF, "#",          -1, END_ON_BYTE, 0, 1, tsv_pkg::ST_OK,           0);
    add_row(1, 16'hFFFF, "$x/+",       -1, END_BARE,    0, 1, tsv_pkg::ST_OK,           1);
    add_row(1, 16'hFFFF, "a+",         -1, END_ON_BYTE, 0, 1, tsv_pkg::ST_BAD_WILDCARD, 0);
    add_row(1, 16'hFFFF, "+a",         -1, END_ON_BYTE, 0, 1, tsv_pkg::ST_BAD_WILDCARD, 0);
    add_row(1, 16'hFFFF, "a/#/b",      -1, END_ON_BYTE, 0, 1, tsv_pkg::ST_BAD_WILDCARD, 0);
    add_row(1, 16'hFFFF, "a#",         -1, END_ON_BYTE, 0, 1, tsv_pkg::ST_BAD_WILDCARD, 0);
    add_row(1, 16'hFFFF, "//",         -1, END_ON_BYTE, 0, 0, tsv_pkg::ST_OK,           0);
    // length limit: at the limit, over it (beats a wildcard), zero
    add_row(1, 16'd3,    "abc",        -1, END_ON_BYTE, 0, 1, tsv_pkg::ST_OK,           0);
    add_row(1, 16'd3,    "ab#c",       -1, END_ON_BYTE, 0, 1, tsv_pkg::ST_TOO_LONG,     0);
    add_row(1, 16'd0,    "",           -1, END_ON_BYTE, 0, 1, tsv_pkg::ST_EMPTY,        0);
    add_row(1, 16'd0,    "/",          -1, END_ON_BYTE, 0, 1, tsv_pkg::ST_TOO_LONG,     0);
    add_row(0, 16'd1,    "$",          -1, END_ON_BYTE, 0, 1, tsv_pkg::ST_OK,           1);
    add_row(0, 16'd1,    "x",           0, END_ON_BYTE, 0, 1, tsv_pkg::ST_NULL_BYTE,    0);
    // mode flipped in the middle of a string: error named by the final mode
    add_row(0, 16'hFFFF, "a+",         -1, END_OPEN,    0, 0, tsv_pkg::ST_OK,           0);
    add_row(1, 16'hFFFF, "/b",         -1, END_ON_BYTE, 0, 0, tsv_pkg::ST_OK,           0);
    add_row(1, 16'hFFFF, "a/#",        -1, END_OPEN,    0, 0, tsv_pkg::ST_OK,           0);
    add_row(0, 16'hFFFF, "c",          -1, END_ON_BYTE, 0, 0, tsv_pkg::ST_OK,           0);

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    foreach (topic_rows[k]) begin
      row = topic_rows[k];
      if (row.mode !== mode_filter || row.limit !== len_limit)
        set_config(row.mode, row.limit);
      n = row.text.len();
      if (n == 0)
        push(8'($urandom_range(0, 255)), 1'b0, 1'b1);
      for (i = 0; i < n; i++) begin
        c = (i == row.nul_at) ? tsv_pkg::CH_NUL : row.text[i];
        if (row.filler && i == n - 1)
          push(8'($urandom_range(0, 255)), 1'b0, 1'b0);
        push(c, 1'b1, row.closing == END_ON_BYTE && i == n - 1);
      end
      if (row.closing == END_BARE)
        push(8'($urandom_range(0, 255)), 1'b0, 1'b1);
      // typed rows: the hand-written status replaces the predicted one
      if (row.typed && row.closing != END_OPEN)
        pending_status[pending_status.size() - 1] = '{row.st, row.sys};
    end

    // Random phases, each under fresh settings with extremes weighted in.
    base = reqs_sent;
    while (reqs_sent - base < RANDOM_REQS) begin
      mode = 1'($urandom_range(0, 1));
      case ($urandom_range(0, 5))
        0: limit = 16'd0;
        1: limit = 16'd1;
        2: limit = 16'hFFFF;
        3: limit = 16'($urandom_range(17, 65534));
        default: limit = 16'($urandom_range(2, 16));
      endcase
      tx_steady = ($urandom_range(0, 3) == 0);
      rx_steady = ($urandom_range(0, 3) == 0);
      set_config(mode, limit);
      n = $urandom_range(5, 25);
      repeat (n) random_topic(1'b0);
      if ($urandom_range(0, 3) == 0)
        random_topic(1'b1);  // carried over into the next settings
    end
    random_topic(1'b0);  // closes any string left open

    s_tvalid <= 1'b0;
    while (pending_status.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Covered %0d requests under %0d settings, %0d statuses compared,",
             reqs_sent, settings_used, statuses_seen);
    $display("including name/filter wildcard rules, NUL, empty and length-limit strings.");
    if (err_count == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

### topic_string_validator.f
rtl/core/tsv_pkg.sv
rtl/core/tsv_cfg.sv
rtl/core/tsv_scan.sv
rtl/core/topic_string_validator.sv
bench/tb_top.sv
